/* rtl/lmt_pkg.sv */
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types, constants and helper functions of the LCD mode timing core.
// ----------------------------------------------------------------------------
`default_nettype none

package lmt_pkg;

  localparam int unsigned CLK_W     = 17;
  localparam int unsigned CYCLES_W  = 10;
  localparam int unsigned APB_AW    = 4;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned IN_TDW    = 16;
  localparam int unsigned OUT_TDW   = 48;

  localparam logic [CLK_W-1:0] CLK_MAX      = 17'h1FFFF;
  localparam logic [CLK_W-1:0] FRAME_CYCLES = 17'd70224;
  localparam logic [7:0]       LAST_LINE    = 8'd153;
  localparam logic [7:0]       LAST_VISIBLE = 8'd143;
  localparam logic [7:0]       VBLANK_LINE  = 8'd144;

  localparam logic [8:0] OAM_CYCLES    = 9'd80;
  localparam logic [8:0] XFER_CYCLES   = 9'd170;
  localparam logic [8:0] HBLANK_CYCLES = 9'd206;
  localparam logic [8:0] LINE_CYCLES   = 9'd456;

  localparam logic [APB_AW-1:0] ADDR_LCD_ENABLE = 4'h0;
  localparam logic [APB_AW-1:0] ADDR_STAT_EN    = 4'h4;
  localparam logic [APB_AW-1:0] ADDR_LYC        = 4'h8;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef struct packed {
    logic       lcd_enable;
    logic [3:0] stat_irq_enables;
    logic [7:0] lyc_compare;
  } cfg_t;

  typedef struct packed {
    logic [CLK_W-1:0] cycles_to_event;
    logic             frame_done;
    logic             clear_screen;
    logic             render_line;
    logic [7:0]       status_read;
    logic             coincidence;
    logic [7:0]       line_now;
    mode_e            mode_now;
    logic             stat_irq;
    logic             vblank_irq;
  } result_t;

  function automatic logic [CLK_W-1:0] sat_add(input logic [CLK_W-1:0] v,
                                               input logic [8:0] d);
    logic [CLK_W:0] s;
    s = {1'b0, v} + {{(CLK_W-8){1'b0}}, d};
    return s[CLK_W] ? CLK_MAX : s[CLK_W-1:0];
  endfunction

  function automatic logic [CLK_W-1:0] frame_wrap(input logic [CLK_W-1:0] v);
    return (v >= FRAME_CYCLES) ? (v - FRAME_CYCLES) : v;
  endfunction

endpackage

`default_nettype wire

/* rtl/lmt_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lmt_cfg_regs
// APB register file holding display enable, status interrupt enables and the
// line compare value.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_cfg_regs
  import lmt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lcd_enable       <= 1'b1;
      cfg_q.stat_irq_enables <= 4'd0;
      cfg_q.lyc_compare      <= 8'd0;
    end else if (wr_en) begin
      case (paddr)
        ADDR_LCD_ENABLE: cfg_q.lcd_enable       <= pwdata[0];
        ADDR_STAT_EN:    cfg_q.stat_irq_enables <= pwdata[3:0];
        ADDR_LYC:        cfg_q.lyc_compare      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_LCD_ENABLE: prdata = {{(APB_DW-1){1'b0}}, cfg_q.lcd_enable};
      ADDR_STAT_EN:    prdata = {{(APB_DW-4){1'b0}}, cfg_q.stat_irq_enables};
      ADDR_LYC:        prdata = {{(APB_DW-8){1'b0}}, cfg_q.lyc_compare};
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/lmt_seq.sv */
// ----------------------------------------------------------------------------
// lmt_seq
// Scan-line mode sequencer: holds the timing state and computes the next
// state and the result of one tick in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_seq
  import lmt_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [CYCLES_W-1:0] cycles_i,
  input  wire cfg_t                cfg_i,
  output result_t                  res_o
);

  logic [CLK_W-1:0] clk_q, clk_d, tgt_q, tgt_d;
  logic [7:0]       line_q, line_d;
  mode_e            mode_q, mode_d, pend_q, pend_d;
  logic             coinc_q, coinc_d;

  always_comb begin
    logic [CLK_W:0] sum;
    logic           sirq, vbl, render, clr, fdone;
    sum     = {1'b0, clk_q} + {{(CLK_W+1-CYCLES_W){1'b0}}, cycles_i};
    clk_d   = sum[CLK_W] ? CLK_MAX : sum[CLK_W-1:0];
    tgt_d   = tgt_q;
    line_d  = line_q;
    mode_d  = mode_q;
    pend_d  = pend_q;
    coinc_d = coinc_q;
    sirq    = 1'b0;
    vbl     = 1'b0;
    render  = 1'b0;
    clr     = 1'b0;
    fdone   = 1'b0;
    if (cfg_i.lcd_enable) begin
      if (clk_d >= tgt_d) begin
        if (line_d == LAST_LINE) begin
          pend_d = MODE_OAM;
          line_d = 8'hFF;
          clk_d  = frame_wrap(clk_d);
          tgt_d  = frame_wrap(tgt_d);
        end
        if (mode_d != pend_d) begin
          mode_d = pend_d;
          if (mode_d != MODE_XFER) begin
            sirq = cfg_i.stat_irq_enables[mode_d];
          end
        end
        case (mode_d)
          MODE_OAM: begin
            tgt_d  = sat_add(tgt_d, OAM_CYCLES);
            pend_d = MODE_XFER;
            line_d = line_d + 8'd1;
            coinc_d = (line_d == cfg_i.lyc_compare);
            sirq   = sirq | (coinc_d & cfg_i.stat_irq_enables[3]);
          end
          MODE_XFER: begin
            tgt_d  = sat_add(tgt_d, XFER_CYCLES);
            pend_d = MODE_HBLANK;
          end
          MODE_HBLANK: begin
            tgt_d = sat_add(tgt_d, HBLANK_CYCLES);
            if (line_d <= LAST_VISIBLE) begin
              render = 1'b1;
              pend_d = MODE_OAM;
            end else begin
              pend_d = MODE_VBLANK;
            end
          end
          default: begin
            tgt_d  = sat_add(tgt_d, LINE_CYCLES);
            pend_d = MODE_VBLANK;
            if (line_d == VBLANK_LINE) begin
              vbl   = 1'b1;
              fdone = 1'b1;
            end
            line_d  = line_d + 8'd1;
            coinc_d = (line_d == cfg_i.lyc_compare);
            sirq    = sirq | (coinc_d & cfg_i.stat_irq_enables[3]);
          end
        endcase
      end
    end else if (clk_d >= FRAME_CYCLES) begin
      fdone = 1'b1;
      clr   = 1'b1;
      clk_d = clk_d - FRAME_CYCLES;
    end

    res_o.vblank_irq      = vbl;
    res_o.stat_irq        = sirq;
    res_o.mode_now        = mode_d;
    res_o.line_now        = line_d;
    res_o.coincidence     = coinc_d;
    res_o.status_read     = {1'b1, cfg_i.stat_irq_enables, coinc_d, mode_d};
    res_o.render_line     = render;
    res_o.clear_screen    = clr;
    res_o.frame_done      = fdone;
    res_o.cycles_to_event = (tgt_d > clk_d) ? (tgt_d - clk_d) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q   <= '0;
      tgt_q   <= '0;
      line_q  <= '0;
      mode_q  <= MODE_HBLANK;
      pend_q  <= MODE_OAM;
      coinc_q <= 1'b0;
    end else if (step_i) begin
      clk_q   <= clk_d;
      tgt_q   <= tgt_d;
      line_q  <= line_d;
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      coinc_q <= coinc_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/lcd_mode_timing_core.sv */
// ----------------------------------------------------------------------------
// lcd_mode_timing_core
// LCD scan-line mode timing and status generator with stream ports and an
// APB configuration port.
// ----------------------------------------------------------------------------
// Each input transaction carries the cycles elapsed since the last one and
// yields exactly one output transaction with the interrupt requests, the mode,
// the line, the status byte and the cycles left to the next event. The core
// takes one transaction per clock cycle while the output is not stalled. An
// item waits in the input register until the result register is free; the
// timing update computes its result and next state combinationally, and both
// are registered together, so the next item can follow at once. Configuration
// must be written only while no transaction is in flight; the block itself
// does not enforce this.
`default_nettype none

module lcd_mode_timing_core
  import lmt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // tdata: [9:0] cycles, [15:10] zero
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [IN_TDW-1:0] s_axis_tdata,
  // tdata: [0] vblank_irq, [1] stat_irq, [3:2] mode_now, [11:4] line_now,
  // [12] coincidence, [20:13] status_read, [21] render_line,
  // [22] clear_screen, [23] frame_done, [40:24] cycles_to_event, [47:41] zero
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OUT_TDW-1:0]     m_axis_tdata,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t                cfg;
  result_t             res, res_q;
  logic                in_valid_q, out_valid_q, out_load;
  logic [CYCLES_W-1:0] cycles_q;

  lmt_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lmt_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (out_load),
    .cycles_i (cycles_q),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cycles_q <= s_axis_tdata[CYCLES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDW-$bits(result_t)){1'b0}}, res_q};

  a_xfer_no_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.mode_now == MODE_XFER) |-> !res_q.stat_irq)
    else $error("status interrupt raised in transfer mode");

  a_clear_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.clear_screen |->
      res_q.frame_done && !res_q.vblank_irq && !res_q.stat_irq)
    else $error("screen clear without frame done or with interrupts");

  a_render_hblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.render_line |->
      (res_q.mode_now == MODE_HBLANK) && (res_q.line_now <= LAST_VISIBLE))
    else $error("line render requested outside visible hblank");

  a_held_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_load |=> in_valid_q && $stable(cycles_q))
    else $error("pending input transaction lost");

endmodule

`default_nettype wire

/* dv/tb_lcd_mode_timing_core.sv */
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_core
// Self-checking testbench for the LCD mode timing core. Tick transactions are
// sent on the input stream, with random gaps, and each one is run through a
// cycle-exact model of the mode sequencer to predict the status transaction
// that must come back. Results are checked field by field while the output
// side stalls at random. Configuration is changed between phases, with the
// core idle, and covers the display off, all interrupt enables and the line
// compare extremes.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_core
  import lmt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_TDW-1:0]   s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_TDW-1:0]  m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  lcd_mode_timing_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  logic [CYCLES_W-1:0] tick_q[$];
  result_t             status_q[$];

  cfg_t             cfg;
  logic [CLK_W-1:0] clk_acc;
  logic [CLK_W-1:0] next_due;
  logic [7:0]       line_q;
  mode_e            mode_cur;
  mode_e            mode_next;
  logic             coin_q;

  int unsigned cyc_n = 0;
  int unsigned fails = 0;
  int unsigned ticks_n = 0;
  int unsigned frames_n = 0;
  int unsigned vblank_n = 0;
  int unsigned render_n = 0;
  int unsigned stat_n = 0;
  int unsigned clear_n = 0;

  result_t want_r;
  result_t seen_r;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [CLK_W-1:0] clamp_add(input logic [CLK_W-1:0] a,
                                                 input logic [9:0] b);
    logic [CLK_W:0] s;
    s = {1'b0, a} + {{(CLK_W-9){1'b0}}, b};
    return s[CLK_W] ? CLK_MAX : s[CLK_W-1:0];
  endfunction

  function automatic logic [CLK_W-1:0] drop_frame(input logic [CLK_W-1:0] v);
    return (v >= FRAME_CYCLES) ? v - FRAME_CYCLES : v;
  endfunction

  function automatic logic bump_line();
    line_q = line_q + 8'd1;
    coin_q = (line_q == cfg.lyc_compare);
    return coin_q & cfg.stat_irq_enables[3];
  endfunction

  function automatic void predict_status(input logic [CYCLES_W-1:0] cyc);
    result_t r;
    r = '0;
    clk_acc = clamp_add(clk_acc, cyc);
    if (cfg.lcd_enable) begin
      if (clk_acc >= next_due) begin
        if (line_q == LAST_LINE) begin
          mode_next = MODE_OAM;
          line_q = 8'hFF;
          clk_acc = drop_frame(clk_acc);
          next_due = drop_frame(next_due);
        end
        if (mode_cur != mode_next) begin
          mode_cur = mode_next;
          if (mode_cur != MODE_XFER) r.stat_irq = cfg.stat_irq_enables[mode_cur];
        end
        case (mode_cur)
          MODE_OAM: begin
            next_due = clamp_add(next_due, {1'b0, OAM_CYCLES});
            mode_next = MODE_XFER;
            r.stat_irq = r.stat_irq | bump_line();
          end
          MODE_XFER: begin
            next_due = clamp_add(next_due, {1'b0, XFER_CYCLES});
            mode_next = MODE_HBLANK;
          end
          MODE_HBLANK: begin
            next_due = clamp_add(next_due, {1'b0, HBLANK_CYCLES});
            if (line_q <= LAST_VISIBLE) begin
              r.render_line = 1'b1;
              mode_next = MODE_OAM;
            end else begin
              mode_next = MODE_VBLANK;
            end
          end
          default: begin
            next_due = clamp_add(next_due, {1'b0, LINE_CYCLES});
            mode_next = MODE_VBLANK;
            if (line_q == VBLANK_LINE) begin
              r.vblank_irq = 1'b1;
              r.frame_done = 1'b1;
            end
            r.stat_irq = r.stat_irq | bump_line();
          end
        endcase
      end
    end else if (clk_acc >= FRAME_CYCLES) begin
      r.frame_done = 1'b1;
      r.clear_screen = 1'b1;
      clk_acc = drop_frame(clk_acc);
    end
    r.mode_now = mode_cur;
    r.line_now = line_q;
    r.coincidence = coin_q;
    r.status_read = {1'b1, cfg.stat_irq_enables, coin_q, mode_cur};
    r.cycles_to_event = (next_due > clk_acc) ? next_due - clk_acc : '0;
    ticks_n++;
    frames_n += r.frame_done;
    vblank_n += r.vblank_irq;
    render_n += r.render_line;
    stat_n += r.stat_irq;
    clear_n += r.clear_screen;
    status_q.push_back(r);
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endfunction

  function automatic logic calm_window();
    return (cyc_n % 2500) >= 1700;
  endfunction

  // Tick driver: a held transaction stays valid until it is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      cyc_n <= cyc_n + 1;
      if (s_axis_tvalid && s_axis_tready) predict_status(s_axis_tdata[CYCLES_W-1:0]);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_q.size() != 0 && (calm_window() || $urandom_range(0, 99) >= 7)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {{(IN_TDW-CYCLES_W){1'b0}}, tick_q.pop_front()};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Status monitor and checker.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (status_q.size() == 0) begin
          $error("status transaction with no expectation: 0x%0h", m_axis_tdata);
          fails++;
        end else begin
          want_r = status_q.pop_front();
          seen_r = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
          check_field("vblank_irq", want_r.vblank_irq, seen_r.vblank_irq);
          check_field("stat_irq", want_r.stat_irq, seen_r.stat_irq);
          check_field("mode_now", want_r.mode_now, seen_r.mode_now);
          check_field("line_now", want_r.line_now, seen_r.line_now);
          check_field("coincidence", want_r.coincidence, seen_r.coincidence);
          check_field("status_read", want_r.status_read, seen_r.status_read);
          check_field("render_line", want_r.render_line, seen_r.render_line);
          check_field("clear_screen", want_r.clear_screen, seen_r.clear_screen);
          check_field("frame_done", want_r.frame_done, seen_r.frame_done);
          check_field("cycles_to_event", want_r.cycles_to_event, seen_r.cycles_to_event);
          check_field("tdata padding", 0, m_axis_tdata[OUT_TDW-1:$bits(result_t)]);
        end
      end
      m_axis_tready <= calm_window() || $urandom_range(0, 99) >= 7;
    end
  end

  task automatic settle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || status_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr)
      ADDR_LCD_ENABLE: cfg.lcd_enable = data[0];
      ADDR_STAT_EN:    cfg.stat_irq_enables = data[3:0];
      ADDR_LYC:        cfg.lyc_compare = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic en, input logic [3:0] irq_en, input logic [7:0] lyc);
    settle();
    write_reg(ADDR_LCD_ENABLE, {{(APB_DW-1){1'b0}}, en});
    write_reg(ADDR_STAT_EN, {{(APB_DW-4){1'b0}}, irq_en});
    write_reg(ADDR_LYC, {{(APB_DW-8){1'b0}}, lyc});
  endtask

  function automatic logic [CYCLES_W-1:0] draw_cycles(input logic en);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (!en) return (pick < 8) ? CYCLES_W'($urandom_range(900, 1023))
                               : CYCLES_W'($urandom_range(0, 1023));
    case (pick)
      0, 1, 2, 3: return CYCLES_W'($urandom_range(0, 255));
      4, 5, 6:    return CYCLES_W'($urandom_range(0, 1023));
      7:          return '0;
      8:          return '1;
      default: begin
        case ($urandom_range(0, 3))
          0:       return CYCLES_W'(OAM_CYCLES);
          1:       return CYCLES_W'(XFER_CYCLES);
          2:       return CYCLES_W'(HBLANK_CYCLES);
          default: return CYCLES_W'(LINE_CYCLES);
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned len;
    logic        en;
    logic [3:0]  irq_en;
    logic [7:0]  lyc;

    cfg = '{lcd_enable: 1'b1, stat_irq_enables: 4'h0, lyc_compare: 8'h00};
    clk_acc = '0;
    next_due = '0;
    line_q = '0;
    mode_cur = MODE_HBLANK;
    mode_next = MODE_OAM;
    coin_q = 1'b0;
    sent = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All status interrupts on, extreme and mode-length tick counts.
    set_cfg(1'b1, 4'hF, 8'd1);
    tick_q = '{10'd0, 10'd1023, 10'd80, 10'd170, 10'd206, 10'd456, 10'd1, 10'd0,
               10'd1023, 10'd1023, 10'd512, 10'd300};
    // No interrupts, compare against a line that is never reached.
    set_cfg(1'b1, 4'h0, 8'hFF);
    tick_q = '{10'd1023, 10'd0, 10'd456, 10'd1023};
    // Display off: lines and modes must hold.
    set_cfg(1'b0, 4'hF, 8'd0);
    tick_q = '{10'd1023, 10'd0, 10'd1023, 10'd5};
    // Coincidence interrupt only.
    set_cfg(1'b1, 4'b1000, 8'd3);
    tick_q = '{10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1};

    while (sent < 900) begin
      en = $urandom_range(0, 9) < 8;
      case ($urandom_range(0, 3))
        0:       irq_en = 4'h0;
        1:       irq_en = 4'hF;
        default: irq_en = 4'($urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 4))
        0:       lyc = 8'h00;
        1:       lyc = 8'hFF;
        2:       lyc = 8'($urandom_range(140, 153));
        default: lyc = 8'($urandom_range(0, 255));
      endcase
      len = en ? $urandom_range(40, 160) : $urandom_range(80, 150);
      if (len > 900 - sent) len = 900 - sent;
      set_cfg(en, irq_en, lyc);
      repeat (len) tick_q.push_back(draw_cycles(en));
      sent += len;
    end

    settle();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d ticks: %0d frames done, %0d vblank, %0d line renders,",
             ticks_n, frames_n, vblank_n, render_n);
    $display("%0d status interrupts and %0d screen clears with the display off.",
             stat_n, clear_n);
    if (fails == 0) begin
      $display("tb_lcd_mode_timing_core passed");
    end else begin
      $display("tb_lcd_mode_timing_core failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_lcd_mode_timing_core failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/lmt_pkg.sv
rtl/lmt_cfg_regs.sv
rtl/lmt_seq.sv
rtl/lcd_mode_timing_core.sv
dv/tb_lcd_mode_timing_core.sv
